[hw/rtl/g711_companding_codec_defines.svh]
// ----------------------------------------------------------------------------
// G.711 companding codec assertion macros
// Shared concurrent assertion forms used by the codec RTL.
// ----------------------------------------------------------------------------
`ifndef G711_COMPANDING_CODEC_DEFINES_SVH
`define G711_COMPANDING_CODEC_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define G711CC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define G711CC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hw/rtl/g711cc_pkg.sv]
// ----------------------------------------------------------------------------
// G.711 codec package
// Types and constants shared by the codec datapath and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package g711cc_pkg;

   localparam int CsrIndexWidth = 2;

   localparam logic [CsrIndexWidth-1:0] CSR_LAW_SELECT = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DIRECTION  = 2'd1;

   localparam logic LAW_MU = 1'b0;
   localparam logic LAW_A  = 1'b1;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   localparam logic [15:0] MU_BIAS   = 16'd132;
   localparam logic [15:0] A_BIAS    = 16'd8;
   localparam logic [15:0] A_SEG_OFS = 16'h0108;
   localparam logic [15:0] PCM_MAX   = 16'h7FFF;
   localparam logic [6:0]  A_MASK    = 7'h55;

   typedef struct packed {
      logic law_select;
      logic direction;
   } cfg_type;

endpackage

`default_nettype wire

[hw/rtl/g711cc_datapath.sv]
// ----------------------------------------------------------------------------
// G.711 codec datapath
// Encodes a linear sample or decodes a code byte under mu-law or A-law.
// ----------------------------------------------------------------------------
`default_nettype none

module g711cc_datapath
   import g711cc_pkg::*;
(
   input  cfg_type            cfg,
   input  logic signed [15:0] pcm_sample,
   input  logic        [7:0]  code_byte,
   output logic        [7:0]  code_out,
   output logic signed [15:0] pcm_out
);

   logic        neg;
   logic [15:0] mag;
   logic [15:0] biased;
   logic [15:0] adj;
   logic [2:0]  enc_seg;
   logic [3:0]  shamt;
   logic [3:0]  mant;
   logic [7:0]  enc_code;
   logic [7:0]  dc;
   logic [2:0]  dec_seg;
   logic [15:0] base;
   logic [15:0] level;
   logic [15:0] dec_pcm;

   always_comb begin
      neg = pcm_sample[15];
      mag = neg ? (~pcm_sample + 16'd1) : pcm_sample;
      if (mag[15]) begin
         mag = PCM_MAX;
      end
      biased = mag + ((cfg.law_select == LAW_A) ? A_BIAS : MU_BIAS);
      adj = biased[15] ? PCM_MAX : biased;

      enc_seg = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if (adj[7+i]) begin
            enc_seg = 3'(i);
         end
      end

      if (cfg.law_select == LAW_A && enc_seg == 3'd0) begin
         shamt = 4'd4;
      end else begin
         shamt = {1'b0, enc_seg} + 4'd3;
      end
      mant = 4'(adj >> shamt);

      if (cfg.law_select == LAW_A) begin
         enc_code = {~neg, {enc_seg, mant} ^ A_MASK};
      end else begin
         enc_code = ~{neg, enc_seg, mant};
      end
   end

   always_comb begin
      if (cfg.law_select == LAW_A) begin
         dc = code_byte ^ {1'b0, A_MASK};
      end else begin
         dc = ~code_byte;
      end
      dec_seg = dc[6:4];

      if (cfg.law_select == LAW_A) begin
         base = {8'd0, dc[3:0], 4'd0};
         if (dec_seg == 3'd0) begin
            level = base + A_BIAS;
         end else begin
            level = (base + A_SEG_OFS) << (dec_seg - 3'd1);
         end
         dec_pcm = dc[7] ? level : (~level + 16'd1);
      end else begin
         base = {9'd0, dc[3:0], 3'd0} + MU_BIAS;
         level = (base << dec_seg) - MU_BIAS;
         dec_pcm = dc[7] ? (~level + 16'd1) : level;
      end
   end

   always_comb begin
      if (cfg.direction == DIR_DECODE) begin
         code_out = 8'd0;
         pcm_out  = dec_pcm;
      end else begin
         code_out = enc_code;
         pcm_out  = 16'sd0;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/g711_companding_codec.sv]
// ----------------------------------------------------------------------------
// G.711 companding codec
// An input register feeds the datapath and a result register holds its output;
// an accepted item's result is valid once it reaches the result register.
// Throughput: one item per cycle while rsp_ready is high; both stages stream.
// Reset: synchronous, clears both valid flags and selects mu-law encoding.
// ----------------------------------------------------------------------------
`default_nettype none

`include "g711_companding_codec_defines.svh"

module g711_companding_codec
   import g711cc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic                     csr_wdata,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [15:0]       req_pcm_sample,
   input  logic        [7:0]        req_code_byte,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic        [7:0]        rsp_code_out,
   output logic signed [15:0]       rsp_pcm_out
);

   cfg_type            cfg_ff, cfg_in;
   logic               s1_valid_ff, s1_valid_in;
   logic signed [15:0] s1_pcm_ff;
   logic        [7:0]  s1_code_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic        [7:0]  rsp_code_out_ff;
   logic signed [15:0] rsp_pcm_out_ff;
   logic        [7:0]  dp_code_out;
   logic signed [15:0] dp_pcm_out;
   logic               s2_load;
   logic               req_take;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LAW_SELECT: cfg_in.law_select = csr_wdata;
            CSR_DIRECTION:  cfg_in.direction  = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   assign s2_load   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s2_load;
   assign req_take  = req_valid && req_ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s2_load);
   assign rsp_valid_in = s2_load || (rsp_valid_ff && !rsp_ready);

   g711cc_datapath u_datapath (
      .cfg        (cfg_ff),
      .pcm_sample (s1_pcm_ff),
      .code_byte  (s1_code_ff),
      .code_out   (dp_code_out),
      .pcm_out    (dp_pcm_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{law_select: LAW_MU, direction: DIR_ENCODE};
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pcm_ff  <= req_pcm_sample;
         s1_code_ff <= req_code_byte;
      end
      if (s2_load) begin
         rsp_code_out_ff <= dp_code_out;
         rsp_pcm_out_ff  <= dp_pcm_out;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_code_out = rsp_code_out_ff;
   assign rsp_pcm_out  = rsp_pcm_out_ff;

   `G711CC_ASSERT_SAME(a_stall_only_when_full, clock, reset, !req_ready, s1_valid_ff && rsp_valid_ff && !rsp_ready)
   `G711CC_ASSERT_NEXT(a_accept_fills_input, clock, reset, req_valid && req_ready, s1_valid_ff)
   `G711CC_ASSERT_NEXT(a_advance_fills_result, clock, reset, s2_load, rsp_valid_ff)
   `G711CC_ASSERT_SAME(a_one_field_zero, clock, reset, rsp_valid_ff, rsp_code_out_ff == 8'd0 || rsp_pcm_out_ff == 16'sd0)

endmodule

`default_nettype wire
